// ===== src/btcf_pkg.sv =====
`default_nettype none
package btcf_pkg;

  typedef enum logic [2:0] {
    PH_KEY      = 3'd0,
    PH_INIT     = 3'd1,
    PH_ENTRY_HI = 3'd2,
    PH_ENTRY_LO = 3'd3,
    PH_SIZE     = 3'd4,
    PH_ADDR_HI  = 3'd5,
    PH_ADDR_LO  = 3'd6,
    PH_DATA     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_CHUNK_LIMIT        = 1'b0,
    CFG_INIT_WORDS_SKIPPED = 1'b1
  } cfg_index_t;

  localparam logic [15:0] CHUNK_LIMIT_RESET = 16'd1024;
  localparam logic [7:0]  INIT_SKIP_RESET   = 8'd8;
  localparam logic [7:0]  END_BYTE          = 8'hA5;
  localparam logic [7:0]  PAD_BYTE          = 8'hFF;
  localparam logic [63:0] PAD_FRAME         = {8{PAD_BYTE}};
  localparam logic [63:0] MARKER_FRAME      = {8{END_BYTE}};

  typedef struct packed {
    logic [63:0] frame_payload;
    kind_t       frame_kind;
    logic        block_complete;
    logic        table_complete;
    logic        table_nonempty;
    logic [31:0] start_addr;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// ===== src/btcf_in_if.sv =====
`default_nettype none
interface btcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface
`default_nettype wire

// ===== src/btcf_out_if.sv =====
`default_nettype none
interface btcf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_payload;
  logic [1:0]  frame_kind;
  logic        block_complete;
  logic        table_complete;
  logic        table_nonempty;
  logic [31:0] start_addr;
  logic        last;

  modport source (output valid, output frame_payload, output frame_kind,
                  output block_complete, output table_complete, output table_nonempty,
                  output start_addr, output last, input ready);
  modport sink (input valid, input frame_payload, input frame_kind,
                input block_complete, input table_complete, input table_nonempty,
                input start_addr, input last, output ready);
endinterface
`default_nettype wire

// ===== src/boot_table_to_can_frames_core.sv =====
// channel   | dir | beat contents
// ----------+-----+--------------------------------------------------------------
// in_chan   | in  | data_byte, end_of_data
// out_chan  | out | frame_payload, frame_kind, block_complete, table_complete,
//           |     | table_nonempty, start_addr, last
// cfg_*     | in  | write enable, register index, 16-bit write data
//
// one input beat per ready cycle; each is decoded in the accept cycle and its
// zero, one or two results go into a four-entry result queue
// in_chan.ready is high while the queue has room for two results, so an item
// that makes two results holds off the next beat only when out_chan stalls
// each result is registered in the queue and goes out behind those ahead of it
// rst_n is synchronous, active low, and brings back the register reset values
`default_nettype none
module boot_table_to_can_frames_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  btcf_in_if.sink          in_chan,
  btcf_out_if.source       out_chan
);

  btcf_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        low_r, low_nxt;
  logic              parity_r, parity_nxt;
  logic [7:0]        skip_r, skip_nxt;
  logic [15:0]       entry_hi_r, entry_hi_nxt;
  logic [31:0]       entry_r, entry_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [31:0]       dest_r, dest_nxt;
  logic [15:0]       sent_r, sent_nxt;
  logic [15:0]       chunk_r, chunk_nxt;
  logic [63:0]       fbuf_r, fbuf_nxt;
  logic [1:0]        fidx_r, fidx_nxt;
  logic              any_r, any_nxt;
  logic [15:0]       max_chunk_r;
  logic [7:0]        init_skip_r;

  btcf_pkg::result_t fifo_r [4];
  logic [1:0]        wr_ptr_r, rd_ptr_r;
  logic [2:0]        cnt_r;

  logic              acc, pop;
  logic [1:0]        n_res;
  btcf_pkg::result_t res0, res1;
  logic [15:0]       w;

  // chunk header unit
  logic [15:0]       hc_left, hc_sent, lim, cw;
  logic [31:0]       hc_dest, hc_addr;
  logic [63:0]       hdr_frame;

  // data word insert
  logic [15:0]       left_dec, chunk_dec, sent_inc;
  logic [63:0]       fbuf_ins;
  logic              chunk_end, block_end;

  assign acc = in_chan.valid && in_chan.ready;
  assign pop = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (cnt_r <= 3'd2);
  assign w = {in_chan.data_byte, low_r};

  assign left_dec  = left_r - 16'd1;
  assign chunk_dec = chunk_r - 16'd1;
  assign sent_inc  = sent_r + 16'd1;
  assign chunk_end = (chunk_dec == 16'd0);
  assign block_end = chunk_end && (left_dec == 16'd0);

  always_comb begin
    fbuf_ins = fbuf_r;
    fbuf_ins[{fidx_r, 4'd0} +: 16] = {w[7:0], w[15:8]};
  end

  always_comb begin
    if (phase_r == btcf_pkg::PH_DATA) begin
      hc_left = left_dec;
      hc_sent = sent_inc;
      hc_dest = dest_r;
    end else begin
      hc_left = left_r;
      hc_sent = 16'd0;
      hc_dest = {dest_r[31:16], w};
    end
    lim       = (max_chunk_r == 16'd0) ? 16'd1 : max_chunk_r;
    cw        = (hc_left < lim) ? hc_left : lim;
    hc_addr   = hc_dest + {16'd0, hc_sent};
    hdr_frame = {btcf_pkg::PAD_BYTE, btcf_pkg::PAD_BYTE,
                 hc_addr[7:0], hc_addr[15:8], hc_addr[23:16], hc_addr[31:24],
                 cw[7:0], cw[15:8]};
  end

  always_comb begin
    phase_nxt    = phase_r;
    low_nxt      = low_r;
    parity_nxt   = parity_r;
    skip_nxt     = skip_r;
    entry_hi_nxt = entry_hi_r;
    entry_nxt    = entry_r;
    left_nxt     = left_r;
    dest_nxt     = dest_r;
    sent_nxt     = sent_r;
    chunk_nxt    = chunk_r;
    fbuf_nxt     = fbuf_r;
    fidx_nxt     = fidx_r;
    any_nxt      = any_r;
    n_res        = 2'd0;

    res0.frame_payload  = 64'd0;
    res0.frame_kind     = btcf_pkg::KIND_ERROR;
    res0.block_complete = 1'b0;
    res0.table_complete = 1'b0;
    res0.table_nonempty = any_r;
    res0.start_addr     = entry_r;
    res0.last           = 1'b1;
    res1                = res0;

    if (acc) begin
      if (in_chan.end_of_data) begin
        n_res      = 2'd1;
        phase_nxt  = btcf_pkg::PH_KEY;
        parity_nxt = 1'b0;
        low_nxt    = 8'd0;
        skip_nxt   = 8'd0;
        left_nxt   = 16'd0;
        sent_nxt   = 16'd0;
        chunk_nxt  = 16'd0;
        any_nxt    = 1'b0;
        fbuf_nxt   = btcf_pkg::PAD_FRAME;
        fidx_nxt   = 2'd0;
      end else if (!parity_r) begin
        low_nxt    = in_chan.data_byte;
        parity_nxt = 1'b1;
      end else begin
        parity_nxt = 1'b0;
        unique case (phase_r)
          btcf_pkg::PH_KEY: begin
            if (init_skip_r == 8'd0) begin
              phase_nxt = btcf_pkg::PH_ENTRY_HI;
            end else begin
              skip_nxt  = init_skip_r;
              phase_nxt = btcf_pkg::PH_INIT;
            end
          end
          btcf_pkg::PH_INIT: begin
            skip_nxt = skip_r - 8'd1;
            if (skip_r == 8'd1) begin
              phase_nxt = btcf_pkg::PH_ENTRY_HI;
            end
          end
          btcf_pkg::PH_ENTRY_HI: begin
            entry_hi_nxt = w;
            phase_nxt    = btcf_pkg::PH_ENTRY_LO;
          end
          btcf_pkg::PH_ENTRY_LO: begin
            entry_nxt = {entry_hi_r, w};
            phase_nxt = btcf_pkg::PH_SIZE;
          end
          btcf_pkg::PH_SIZE: begin
            if (w == 16'd0) begin
              n_res               = 2'd2;
              res0.frame_payload  = btcf_pkg::MARKER_FRAME;
              res0.frame_kind     = btcf_pkg::KIND_END;
              res0.last           = 1'b0;
              res1.frame_payload  = btcf_pkg::MARKER_FRAME;
              res1.frame_kind     = btcf_pkg::KIND_END;
              res1.table_complete = 1'b1;
              phase_nxt  = btcf_pkg::PH_KEY;
              low_nxt    = 8'd0;
              skip_nxt   = 8'd0;
              left_nxt   = 16'd0;
              sent_nxt   = 16'd0;
              chunk_nxt  = 16'd0;
              any_nxt    = 1'b0;
              fbuf_nxt   = btcf_pkg::PAD_FRAME;
              fidx_nxt   = 2'd0;
            end else begin
              left_nxt  = w;
              any_nxt   = 1'b1;
              phase_nxt = btcf_pkg::PH_ADDR_HI;
            end
          end
          btcf_pkg::PH_ADDR_HI: begin
            dest_nxt  = {w, 16'd0};
            phase_nxt = btcf_pkg::PH_ADDR_LO;
          end
          btcf_pkg::PH_ADDR_LO: begin
            dest_nxt            = hc_dest;
            sent_nxt            = 16'd0;
            fbuf_nxt            = btcf_pkg::PAD_FRAME;
            fidx_nxt            = 2'd0;
            chunk_nxt           = cw;
            n_res               = 2'd1;
            res0.frame_payload  = hdr_frame;
            res0.frame_kind     = btcf_pkg::KIND_HEADER;
            res0.table_nonempty = any_r;
            phase_nxt           = btcf_pkg::PH_DATA;
          end
          btcf_pkg::PH_DATA: begin
            left_nxt  = left_dec;
            sent_nxt  = sent_inc;
            chunk_nxt = chunk_dec;
            fbuf_nxt  = fbuf_ins;
            fidx_nxt  = fidx_r + 2'd1;
            if ((fidx_r == 2'd3) || chunk_end) begin
              n_res               = 2'd1;
              res0.frame_payload  = fbuf_ins;
              res0.frame_kind     = btcf_pkg::KIND_DATA;
              res0.block_complete = block_end;
              fbuf_nxt            = btcf_pkg::PAD_FRAME;
              fidx_nxt            = 2'd0;
            end
            if (block_end) begin
              phase_nxt = btcf_pkg::PH_SIZE;
            end else if (chunk_end) begin
              n_res              = 2'd2;
              res0.last          = 1'b0;
              res1.frame_payload = hdr_frame;
              res1.frame_kind    = btcf_pkg::KIND_HEADER;
              chunk_nxt          = cw;
            end
          end
          default: begin
            phase_nxt = btcf_pkg::PH_KEY;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= btcf_pkg::PH_KEY;
      low_r       <= 8'd0;
      parity_r    <= 1'b0;
      skip_r      <= 8'd0;
      entry_hi_r  <= 16'd0;
      entry_r     <= 32'd0;
      left_r      <= 16'd0;
      dest_r      <= 32'd0;
      sent_r      <= 16'd0;
      chunk_r     <= 16'd0;
      fbuf_r      <= btcf_pkg::PAD_FRAME;
      fidx_r      <= 2'd0;
      any_r       <= 1'b0;
      max_chunk_r <= btcf_pkg::CHUNK_LIMIT_RESET;
      init_skip_r <= btcf_pkg::INIT_SKIP_RESET;
    end else begin
      phase_r    <= phase_nxt;
      low_r      <= low_nxt;
      parity_r   <= parity_nxt;
      skip_r     <= skip_nxt;
      entry_hi_r <= entry_hi_nxt;
      entry_r    <= entry_nxt;
      left_r     <= left_nxt;
      dest_r     <= dest_nxt;
      sent_r     <= sent_nxt;
      chunk_r    <= chunk_nxt;
      fbuf_r     <= fbuf_nxt;
      fidx_r     <= fidx_nxt;
      any_r      <= any_nxt;
      if (cfg_we) begin
        unique case (btcf_pkg::cfg_index_t'(cfg_index))
          btcf_pkg::CFG_CHUNK_LIMIT:        max_chunk_r <= cfg_data;
          btcf_pkg::CFG_INIT_WORDS_SKIPPED: init_skip_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_res;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {1'b0, n_res} - {2'b00, pop};
    end
  end

  assign out_chan.valid          = (cnt_r != 3'd0);
  assign out_chan.frame_payload  = fifo_r[rd_ptr_r].frame_payload;
  assign out_chan.frame_kind     = fifo_r[rd_ptr_r].frame_kind;
  assign out_chan.block_complete = fifo_r[rd_ptr_r].block_complete;
  assign out_chan.table_complete = fifo_r[rd_ptr_r].table_complete;
  assign out_chan.table_nonempty = fifo_r[rd_ptr_r].table_nonempty;
  assign out_chan.start_addr     = fifo_r[rd_ptr_r].start_addr;
  assign out_chan.last           = fifo_r[rd_ptr_r].last;

endmodule
`default_nettype wire

// ===== tb/btcf_frame_checker.sv =====
module btcf_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  btcf_in_if          in_mon,
  btcf_out_if         out_mon,
  output int          fail_count,
  output int          frames_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] chunk_limit;
  logic [7:0]  skip_setting;

  btcf_pkg::phase_t phase;
  logic [7:0]  low_byte;
  logic        odd_byte;
  logic [7:0]  skip_left;
  logic [15:0] entry_hi;
  logic [31:0] entry_addr;
  logic [15:0] block_left;
  logic [31:0] block_base;
  logic [15:0] block_sent;
  logic [15:0] chunk_left;
  logic [63:0] frame_buf;
  logic [3:0]  frame_fill;
  logic        block_seen;

  btcf_pkg::result_t frames_due[$];
  btcf_pkg::result_t step_frames[$];

  initial begin
    fail_count = 0;
    frames_outstanding = 0;
  end

  function automatic logic [63:0] swap_in_words(input logic [63:0] x);
    logic [63:0] m;
    m = 64'h00FF_00FF_00FF_00FF;
    return ((x & m) << 8) | ((x >> 8) & m);
  endfunction

  task clear_table();
    phase = btcf_pkg::PH_KEY;
    odd_byte = 1'b0;
    low_byte = '0;
    skip_left = '0;
    block_left = '0;
    block_sent = '0;
    chunk_left = '0;
    block_seen = 1'b0;
    frame_buf = btcf_pkg::PAD_FRAME;
    frame_fill = '0;
  endtask

  task add_frame(input logic [63:0] payload, input btcf_pkg::kind_t kind,
                 input logic blk_done, input logic tbl_done);
    btcf_pkg::result_t r;
    r.frame_payload = payload;
    r.frame_kind = kind;
    r.block_complete = blk_done;
    r.table_complete = tbl_done;
    r.table_nonempty = block_seen;
    r.start_addr = entry_addr;
    r.last = 1'b0;
    step_frames.push_back(r);
  endtask

  task open_chunk();
    logic [15:0] span;
    logic [15:0] words;
    logic [31:0] addr;
    span = (chunk_limit == 16'd0) ? 16'd1 : chunk_limit;
    words = (block_left < span) ? block_left : span;
    addr = block_base + {16'd0, block_sent};
    chunk_left = words;
    add_frame(swap_in_words({16'hFFFF, addr[15:0], addr[31:16], words}),
              btcf_pkg::KIND_HEADER, 1'b0, 1'b0);
  endtask

  task predict_step(input logic [7:0] b, input logic eod);
    logic [15:0] w;
    int sh;
    logic chunk_end;
    logic block_end;
    btcf_pkg::result_t r;
    step_frames.delete();
    if (eod) begin
      add_frame('0, btcf_pkg::KIND_ERROR, 1'b0, 1'b0);
      clear_table();
    end else if (!odd_byte) begin
      low_byte = b;
      odd_byte = 1'b1;
    end else begin
      odd_byte = 1'b0;
      w = {b, low_byte};
      case (phase)
        btcf_pkg::PH_KEY: begin
          if (skip_setting == 8'd0) begin
            phase = btcf_pkg::PH_ENTRY_HI;
          end else begin
            skip_left = skip_setting;
            phase = btcf_pkg::PH_INIT;
          end
        end
        btcf_pkg::PH_INIT: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0) phase = btcf_pkg::PH_ENTRY_HI;
        end
        btcf_pkg::PH_ENTRY_HI: begin
          entry_hi = w;
          phase = btcf_pkg::PH_ENTRY_LO;
        end
        btcf_pkg::PH_ENTRY_LO: begin
          entry_addr = {entry_hi, w};
          phase = btcf_pkg::PH_SIZE;
        end
        btcf_pkg::PH_SIZE: begin
          if (w == 16'd0) begin
            add_frame(btcf_pkg::MARKER_FRAME, btcf_pkg::KIND_END, 1'b0, 1'b0);
            add_frame(btcf_pkg::MARKER_FRAME, btcf_pkg::KIND_END, 1'b0, 1'b1);
            clear_table();
          end else begin
            block_left = w;
            block_seen = 1'b1;
            phase = btcf_pkg::PH_ADDR_HI;
          end
        end
        btcf_pkg::PH_ADDR_HI: begin
          block_base = {w, 16'd0};
          phase = btcf_pkg::PH_ADDR_LO;
        end
        btcf_pkg::PH_ADDR_LO: begin
          block_base[15:0] = w;
          block_sent = '0;
          frame_buf = btcf_pkg::PAD_FRAME;
          frame_fill = '0;
          open_chunk();
          phase = btcf_pkg::PH_DATA;
        end
        default: begin
          sh = frame_fill[2:1] * 16;
          frame_buf[sh +: 16] = w;
          frame_fill = {1'b0, frame_fill[2:1], 1'b0} + 4'd2;
          chunk_left = chunk_left - 16'd1;
          block_left = block_left - 16'd1;
          block_sent = block_sent + 16'd1;
          chunk_end = (chunk_left == 16'd0);
          block_end = chunk_end && (block_left == 16'd0);
          if (frame_fill >= 4'd8 || chunk_end) begin
            add_frame(swap_in_words(frame_buf), btcf_pkg::KIND_DATA, block_end, 1'b0);
            frame_buf = btcf_pkg::PAD_FRAME;
            frame_fill = '0;
          end
          if (block_end) phase = btcf_pkg::PH_SIZE;
          else if (chunk_end) open_chunk();
        end
      endcase
    end
    if (step_frames.size() > 0) begin
      r = step_frames.pop_back();
      r.last = 1'b1;
      step_frames.push_back(r);
    end
    foreach (step_frames[i]) frames_due.push_back(step_frames[i]);
  endtask

  task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s expected %h actual %h", name, want, got);
      fail_count++;
    end
  endtask

  task check_beat();
    btcf_pkg::result_t want;
    if (frames_due.size() == 0) begin
      $error("result beat with no frame pending: kind %0d payload %h",
             out_mon.frame_kind, out_mon.frame_payload);
      fail_count++;
    end else begin
      want = frames_due.pop_front();
      check_field("frame_payload", want.frame_payload, out_mon.frame_payload);
      check_field("frame_kind", 64'(want.frame_kind), 64'(out_mon.frame_kind));
      check_field("block_complete", 64'(want.block_complete), 64'(out_mon.block_complete));
      check_field("table_complete", 64'(want.table_complete), 64'(out_mon.table_complete));
      check_field("table_nonempty", 64'(want.table_nonempty), 64'(out_mon.table_nonempty));
      check_field("start_addr", 64'(want.start_addr), 64'(out_mon.start_addr));
      check_field("last", 64'(want.last), 64'(out_mon.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chunk_limit = btcf_pkg::CHUNK_LIMIT_RESET;
      skip_setting = btcf_pkg::INIT_SKIP_RESET;
      entry_hi = '0;
      entry_addr = '0;
      block_base = '0;
      clear_table();
      frames_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_beat();
      if (in_mon.valid && in_mon.ready) predict_step(in_mon.data_byte, in_mon.end_of_data);
      if (cfg_we) begin
        if (cfg_index == btcf_pkg::CFG_CHUNK_LIMIT) chunk_limit = cfg_data;
        else skip_setting = cfg_data[7:0];
      end
    end
    frames_outstanding = frames_due.size();
  end

endmodule

// ===== tb/boot_table_to_can_frames_core_tb.sv =====
module boot_table_to_can_frames_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  btcf_pkg::cfg_index_t cfg_index;
  logic [15:0]          cfg_data;
  int                   fail_count;
  int                   frames_outstanding;
  int                   in_idle_pct;
  int                   out_idle_pct;
  logic [8:0]           beat_q[$];

  btcf_in_if  in_if();
  btcf_out_if out_if();

  boot_table_to_can_frames_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  btcf_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_mon            (in_if),
    .out_mon           (out_if),
    .fail_count        (fail_count),
    .frames_outstanding(frames_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic push_word(input logic [15:0] w);
    beat_q.push_back({1'b0, w[7:0]});
    beat_q.push_back({1'b0, w[15:8]});
  endtask

  task automatic build_table(input logic [7:0] skip_words);
    int n_blocks;
    logic [15:0] blk_words;
    logic [31:0] dest;
    beat_q.delete();
    push_word(16'($urandom));
    repeat (skip_words) push_word(16'($urandom));
    push_word(16'($urandom));
    push_word(16'($urandom));
    n_blocks = $urandom_range(0, 3);
    repeat (n_blocks) begin
      blk_words = ($urandom_range(9) == 0) ? 16'($urandom_range(13, 40))
                                           : 16'($urandom_range(1, 12));
      dest = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(20) : $urandom;
      push_word(blk_words);
      push_word(dest[31:16]);
      push_word(dest[15:0]);
      repeat (blk_words) push_word(16'($urandom));
    end
    push_word(16'd0);
  endtask

  task automatic drive_beat(input logic [8:0] beat);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= beat[7:0];
    in_if.end_of_data <= beat[8];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_queue();
    foreach (beat_q[i]) drive_beat(beat_q[i]);
  endtask

  // sender holds off until every pending frame has drained
  task automatic settle();
    in_if.valid <= 1'b0;
    while (frames_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config(input logic [15:0] limit_words, input logic [7:0] skip_words);
    cfg_we <= 1'b1;
    cfg_index <= btcf_pkg::CFG_CHUNK_LIMIT;
    cfg_data <= limit_words;
    @(negedge clk);
    cfg_index <= btcf_pkg::CFG_INIT_WORDS_SKIPPED;
    cfg_data <= {8'($urandom), skip_words};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] chunk_plan[8];
    logic [7:0]  skip_plan[8];
    logic [15:0] chunk_cfg;
    logic [7:0]  skip_cfg;
    int beats_sent;
    int pick;
    int cut;
    chunk_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd4, 16'd0, 16'd1024, 16'd7, 16'd2};
    skip_plan = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd0, 8'd8, 8'd0, 8'd3};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = btcf_pkg::CFG_CHUNK_LIMIT;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_data = 1'b0;
    out_if.ready = 1'b0;
    in_idle_pct = 18;
    out_idle_pct = 18;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // early end, then one two-chunk block that wraps the address, then end frames
    load_config(16'd3, 8'd0);
    beat_q.delete();
    beat_q.push_back({1'b1, 8'hFF});
    push_word(16'hFF00);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_word(16'd5);
    push_word(16'hFFFF);
    push_word(16'hFFFE);
    push_word(16'h8001);
    push_word(16'h4002);
    push_word(16'h2003);
    push_word(16'h1004);
    push_word(16'h0805);
    push_word(16'h0000);
    send_queue();

    for (int p = 0; p < 8; p++) begin
      settle();
      chunk_cfg = chunk_plan[p];
      skip_cfg = skip_plan[p];
      if (p == 4) begin
        chunk_cfg = 16'($urandom_range(1, 9));
        skip_cfg = 8'($urandom_range(0, 4));
      end
      load_config(chunk_cfg, skip_cfg);
      in_idle_pct = (p == 3) ? 0 : 18;
      out_idle_pct = (p == 3) ? 0 : 18;
      beats_sent = 0;
      while (beats_sent < 160) begin
        build_table(skip_cfg);
        pick = $urandom_range(99);
        if (pick >= 90) begin
          beat_q.delete();
          repeat ($urandom_range(1, 7)) beat_q.push_back({1'b0, 8'($urandom)});
          beat_q.push_back({1'b1, 8'($urandom)});
        end else if (pick >= 75) begin
          cut = $urandom_range(0, beat_q.size() - 1);
          while (beat_q.size() > cut) void'(beat_q.pop_back());
          beat_q.push_back({1'b1, 8'($urandom)});
        end else if (pick >= 70) begin
          beat_q.push_back({1'b1, 8'($urandom)});
        end
        beats_sent += beat_q.size();
        send_queue();
      end
    end
    settle();

    if (fail_count == 0 && frames_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
